/* rtl/cvm_pkg.sv */
// Shared constants, codes and types of the closed-set visited map.
package cvm_pkg;

    // Store geometry
    localparam int MAX_CELLS = 4096;
    localparam int CELL_AW   = $clog2(MAX_CELLS);
    localparam int MAX_BINS  = 64;                 // power of two
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int EPOCH_W   = 16;
    localparam int ENTRY_W   = EPOCH_W + MAX_BINS; // tag over bitmap

    // Field widths
    localparam int KIND_W    = 2;
    localparam int COORD_W   = 12;
    localparam int HEAD_W    = 16;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // Address arithmetic widths
    localparam int PROD_W    = COORD_W + CFG_W;
    localparam int FULL_W    = PROD_W + 1;

    // Heading arithmetic, 1/16 degree units
    localparam int FULL_TURN   = 5760;
    localparam int TURN_OFFSET = 6 * FULL_TURN;
    localparam int ANG_W       = 13;
    localparam int SUM_W       = HEAD_W + 1;
    localparam int DIV_W       = CFG_W + BIN_W;
    localparam int IDX_W       = $clog2(BIN_W);

    // Word kinds
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EPOCH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 2'd2;

    localparam logic [CFG_W-1:0]   RST_CELLS_X   = 13'd64;
    localparam logic [CFG_W-1:0]   RST_CELLS_Y   = 13'd64;
    localparam logic [CFG_W-1:0]   RST_BIN_WIDTH = 13'd160;
    localparam logic [EPOCH_W-1:0] RST_EPOCH     = 16'd1;

    // Bin unit command and status
    typedef struct packed {
        logic              start;
        logic [HEAD_W-1:0] heading;
        logic [CFG_W-1:0]  width;
    } bin_cmd_t;

    typedef struct packed {
        logic             valid;
        logic [BIN_W-1:0] bin;
    } bin_res_t;

endpackage

/* rtl/cvm_ram.sv */
// Generic simple dual-port RAM with registered read.
module cvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/cvm_bin_div.sv */
// Heading bin unit: wrap to one turn, then bit-serial divide by the bin width.
module cvm_bin_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  cvm_pkg::bin_cmd_t cmd,
    output cvm_pkg::bin_res_t res
);
    import cvm_pkg::*;

    localparam logic [2:0] BD_IDLE = 3'd0;
    localparam logic [2:0] BD_MOD  = 3'd1;
    localparam logic [2:0] BD_SAT  = 3'd2;
    localparam logic [2:0] BD_DIV  = 3'd3;
    localparam logic [2:0] BD_DONE = 3'd4;

    logic [2:0]        st_reg;
    logic [HEAD_W-1:0] h_reg;
    logic [CFG_W-1:0]  w_reg;
    logic [ANG_W-1:0]  rem_reg;
    logic [BIN_W-1:0]  q_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [DIV_W-1:0]  step_div;
    logic [DIV_W-1:0]  sat_div;
    logic              step_fits;

    // Reduce to 0..FULL_TURN-1 with four conditional subtracts
    function automatic logic [ANG_W-1:0] wrap_turn(input logic [HEAD_W-1:0] h);
        logic [SUM_W-1:0] u;
        u = {h[HEAD_W-1], h} + SUM_W'(TURN_OFFSET);
        for (int k = 3; k >= 0; k--) begin
            if (u >= (SUM_W'(FULL_TURN) << k)) begin
                u = u - (SUM_W'(FULL_TURN) << k);
            end
        end
        return u[ANG_W-1:0];
    endfunction

    assign step_div  = DIV_W'(w_reg) << i_reg;
    assign sat_div   = DIV_W'(w_reg) << BIN_W;
    assign step_fits = (DIV_W'(rem_reg) >= step_div);

    // Sequencer: one quotient bit per cycle, saturating at the last bin
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= BD_IDLE;
        end else if (cmd.start) begin
            st_reg <= BD_MOD;
        end else begin
            unique case (st_reg)
                BD_MOD:  st_reg <= BD_SAT;
                BD_SAT:  st_reg <= (DIV_W'(rem_reg) >= sat_div) ? BD_DONE : BD_DIV;
                BD_DIV:  st_reg <= (i_reg == '0) ? BD_DONE : BD_DIV;
                default: st_reg <= st_reg;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            h_reg <= cmd.heading;
            w_reg <= (cmd.width == '0) ? CFG_W'(1) : cmd.width;
        end else begin
            case (st_reg)
                BD_MOD: begin
                    rem_reg <= wrap_turn(h_reg);
                end
                BD_SAT: begin
                    q_reg <= (DIV_W'(rem_reg) >= sat_div) ? '1 : '0;
                    i_reg <= IDX_W'(BIN_W - 1);
                end
                BD_DIV: begin
                    if (step_fits) begin
                        rem_reg      <= rem_reg - step_div[ANG_W-1:0];
                        q_reg[i_reg] <= 1'b1;
                    end
                    i_reg <= i_reg - IDX_W'(1);
                end
                default: ;
            endcase
        end
    end

    assign res.valid = (st_reg == BD_DONE);
    assign res.bin   = q_reg;

endmodule

/* rtl/closed_set_visited_map.sv */
// Top level of the closed-set visited map: sequencer, cell store, config.
//
//  channel | dir | handshake               | payload
//  s_      | in  | s_valid / s_ready       | s_kind, s_cell_x, s_cell_y, s_heading
//  m_      | out | m_valid / m_ready       | m_closed, m_out_of_map
//  cfg_    | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// An on-map word waits for the bit-serial heading bin divider (one quotient bit per cycle);
// a heading past the last bin saturates early and skips the divide. An off-map word does not
// wait for the divider or the cell store; an epoch or unused word never leaves the idle state.
// After reset a clearing pass writes every cell store entry with s_ready low; configuration
// writes are taken throughout. A finished query result waits in the output register while
// the next word runs; only a second one stalls.
module closed_set_visited_map (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cvm_pkg::KIND_W-1:0]        s_kind,
    input  logic [cvm_pkg::COORD_W-1:0]       s_cell_x,
    input  logic [cvm_pkg::COORD_W-1:0]       s_cell_y,
    input  logic signed [cvm_pkg::HEAD_W-1:0] s_heading,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_closed,
    output logic                              m_out_of_map,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cvm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cvm_pkg::CFG_W-1:0]         cfg_data
);
    import cvm_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MULT  = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [CELL_AW-1:0] clr_idx_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [CELL_AW-1:0] addr_reg;
    logic               res_closed_reg;
    logic               res_oob_reg;
    logic               m_valid_reg;
    logic               m_closed_reg;
    logic               m_oob_reg;
    logic [CFG_W-1:0]   cells_x_reg;
    logic [CFG_W-1:0]   cells_y_reg;
    logic [CFG_W-1:0]   bin_width_reg;
    logic [EPOCH_W-1:0] epoch_reg;

    logic               in_acc;
    logic               is_cell_word;
    logic [FULL_W-1:0]  full_addr;
    logic               off_map;
    logic               out_free;
    bin_cmd_t           bin_cmd;
    bin_res_t           bin_res;

    logic               ram_we;
    logic [CELL_AW-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [EPOCH_W-1:0] rd_tag;
    logic [MAX_BINS-1:0] bm_cur;
    logic [MAX_BINS-1:0] bm_new;
    logic               hit;

    assign s_ready      = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign in_acc       = s_valid && s_ready;
    assign is_cell_word = (s_kind == KIND_QUERY) || (s_kind == KIND_CLOSE);
    assign out_free     = !m_valid_reg || m_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cells_x_reg   <= RST_CELLS_X;
            cells_y_reg   <= RST_CELLS_Y;
            bin_width_reg <= RST_BIN_WIDTH;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CELLS_X:   cells_x_reg   <= cfg_data;
                CFG_CELLS_Y:   cells_y_reg   <= cfg_data;
                CFG_BIN_WIDTH: bin_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Epoch counter, wraps freely
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg <= RST_EPOCH;
        end else if (in_acc && s_kind == KIND_EPOCH) begin
            epoch_reg <= epoch_reg + EPOCH_W'(1);
        end
    end

    // Heading bin unit runs alongside the address path
    assign bin_cmd.start   = in_acc && is_cell_word;
    assign bin_cmd.heading = s_heading;
    assign bin_cmd.width   = bin_width_reg;

    cvm_bin_div u_bin (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (bin_cmd),
        .res     (bin_res)
    );

    // Cell address and map bounds
    assign full_addr = FULL_W'(prod_reg) + FULL_W'(x_reg);
    assign off_map   = ({1'b0, x_reg} >= cells_x_reg) || ({1'b0, y_reg} >= cells_y_reg)
                     || (full_addr >= FULL_W'(MAX_CELLS));

    // Refresh and update of the cell entry
    assign rd_tag = ram_rdata[ENTRY_W-1 -: EPOCH_W];
    assign bm_cur = (rd_tag == epoch_reg) ? ram_rdata[MAX_BINS-1:0] : '0;
    assign bm_new = (kind_reg == KIND_CLOSE) ? (bm_cur | (MAX_BINS'(1) << bin_res.bin))
                                             : bm_cur;
    assign hit    = bm_cur[bin_res.bin];

    // Cell store port control
    assign ram_re    = (state_reg == S_ADDR) && !off_map;
    assign ram_we    = (state_reg == S_CLEAR) || ((state_reg == S_WAIT) && bin_res.valid);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_idx_reg : addr_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : {epoch_reg, bm_new};

    cvm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CELLS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (full_addr[CELL_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_idx_reg == CELL_AW'(MAX_CELLS - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc && is_cell_word) state_next = S_MULT;
            end
            S_MULT: state_next = S_ADDR;
            S_ADDR: begin
                if (off_map) begin
                    state_next = (kind_reg == KIND_QUERY) ? S_RESP : S_IDLE;
                end else begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (bin_res.valid) begin
                    state_next = (kind_reg == KIND_QUERY) ? S_RESP : S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + CELL_AW'(1);
            end
        end
    end

    // Word capture, address and result registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            kind_reg <= s_kind;
            x_reg    <= s_cell_x;
            y_reg    <= s_cell_y;
        end
        if (state_reg == S_MULT) begin
            prod_reg <= PROD_W'(y_reg) * PROD_W'(cells_x_reg);
        end
        if (state_reg == S_ADDR) begin
            addr_reg       <= full_addr[CELL_AW-1:0];
            res_closed_reg <= 1'b1;
            res_oob_reg    <= 1'b1;
        end
        if (state_reg == S_WAIT && bin_res.valid) begin
            res_closed_reg <= hit;
            res_oob_reg    <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_RESP && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_RESP && out_free) begin
            m_closed_reg <= res_closed_reg;
            m_oob_reg    <= res_oob_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_closed     = m_closed_reg;
    assign m_out_of_map = m_oob_reg;

    // Checks
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("cell store read and written in one cycle");

    a_oob_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_of_map) |-> m_closed)
        else $error("off-map result not reported closed");

    a_epoch_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && epoch_reg != $past(epoch_reg))
        |-> $past(s_valid && s_ready && s_kind == KIND_EPOCH))
        else $error("epoch moved without an epoch word");

    a_wb_has_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg != S_CLEAR) |-> bin_res.valid)
        else $error("cell write-back before heading bin is ready");

endmodule

/* dv/closed_set_visited_map_tb.sv */
// Self-checking testbench for the closed-set visited map: stimulus, predictor, checker.
module closed_set_visited_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cvm_pkg::*;

    localparam int HOT_CELLS      = 8;
    localparam int HOT_HEADS      = 6;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_LIMIT   = 10;

    // Receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_TOGGLE = 3;

    typedef struct {
        logic [KIND_W-1:0]        kind;
        logic [COORD_W-1:0]       cell_x;
        logic [COORD_W-1:0]       cell_y;
        logic signed [HEAD_W-1:0] heading;
    } map_word_t;

    typedef struct packed {
        logic closed;
        logic out_of_map;
    } map_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [KIND_W-1:0]          s_kind = KIND_QUERY;
    logic [COORD_W-1:0]         s_cell_x = '0;
    logic [COORD_W-1:0]         s_cell_y = '0;
    logic signed [HEAD_W-1:0]   s_heading = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_closed;
    logic                       m_out_of_map;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = CFG_CELLS_X;
    logic [CFG_W-1:0]           cfg_data = '0;

    closed_set_visited_map dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_cell_x     (s_cell_x),
        .s_cell_y     (s_cell_y),
        .s_heading    (s_heading),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_closed     (m_closed),
        .m_out_of_map (m_out_of_map),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Words waiting for the sender, results waiting for the checker
    map_word_t   pending_words[$];
    map_result_t expected_results[$];

    // Predictor copy of the map
    logic [CFG_W-1:0]    model_cells_x;
    logic [CFG_W-1:0]    model_cells_y;
    logic [CFG_W-1:0]    model_bin_width;
    logic [EPOCH_W-1:0]  model_epoch;
    logic [EPOCH_W-1:0]  tag_mem  [MAX_CELLS];
    logic [MAX_BINS-1:0] bins_mem [MAX_CELLS];

    // Geometry the stimulus is planned for, and its hot spots
    int unsigned plan_cells_x;
    int unsigned plan_cells_y;
    int unsigned plan_bin_width;
    int          hot_count;
    logic [COORD_W-1:0] hot_x [HOT_CELLS];
    logic [COORD_W-1:0] hot_y [HOT_CELLS];
    int          hot_heads [HOT_HEADS];

    // Bookkeeping
    int mismatches      = 0;
    int words_accepted  = 0;
    int epochs_started  = 0;
    int results_checked = 0;
    int closed_hits     = 0;
    int off_map_results = 0;
    int settings_run    = 0;
    int hold_requests   = 0;
    int hold_served     = 0;

    // ---------------------------------------------------------------- predictor

    function automatic bit cell_address(input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y,
                                        output int unsigned addr);
        int unsigned a;
        a = int'(y) * int'(model_cells_x) + int'(x);
        addr = a;
        return !(x >= model_cells_x || y >= model_cells_y || a >= MAX_CELLS);
    endfunction

    function automatic int unsigned heading_bin(input logic signed [HEAD_W-1:0] h);
        int          hv;
        int unsigned wd;
        int unsigned b;
        hv = h;
        wd = (model_bin_width == 0) ? 1 : model_bin_width;
        b  = ((hv + TURN_OFFSET) % FULL_TURN) / wd;
        if (b >= MAX_BINS)
            b = MAX_BINS - 1;
        return b;
    endfunction

    task automatic reset_model();
        model_cells_x   = RST_CELLS_X;
        model_cells_y   = RST_CELLS_Y;
        model_bin_width = RST_BIN_WIDTH;
        model_epoch     = RST_EPOCH;
        for (int i = 0; i < MAX_CELLS; i++) begin
            tag_mem[i]  = '0;
            bins_mem[i] = '0;
        end
    endtask

    // Update the map for one accepted word and queue its result, if any
    task automatic apply_word(input map_word_t w);
        int unsigned addr;
        int unsigned bin;
        map_result_t r;
        words_accepted++;
        case (w.kind)
            KIND_EPOCH: begin
                model_epoch = model_epoch + 1'b1;
                epochs_started++;
            end
            KIND_NONE: ;
            default: begin
                if (!cell_address(w.cell_x, w.cell_y, addr)) begin
                    // off map: query reports closed, close is dropped
                    if (w.kind == KIND_QUERY) begin
                        r.closed     = 1'b1;
                        r.out_of_map = 1'b1;
                        expected_results.push_back(r);
                    end
                end else begin
                    bin = heading_bin(w.heading);
                    // stale tag: the cell reads as empty in this epoch
                    if (tag_mem[addr] != model_epoch) begin
                        tag_mem[addr]  = model_epoch;
                        bins_mem[addr] = '0;
                    end
                    if (w.kind == KIND_CLOSE) begin
                        bins_mem[addr][bin] = 1'b1;
                    end else begin
                        r.closed     = bins_mem[addr][bin];
                        r.out_of_map = 1'b0;
                        expected_results.push_back(r);
                    end
                end
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input map_result_t want,
                                 input map_result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch @%0t: %s: closed exp %b got %b, out_of_map exp %b got %b",
                     $time, what, want.closed, got.closed, want.out_of_map, got.out_of_map);
    endtask

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin : monitor
        map_word_t   w;
        map_result_t got;
        map_result_t want;
        if (!aresetn) begin
            reset_model();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CELLS_X:   model_cells_x   = cfg_data;
                    CFG_CELLS_Y:   model_cells_y   = cfg_data;
                    CFG_BIN_WIDTH: model_bin_width = cfg_data;
                    default: ;
                endcase
            end
            // accepted input word
            if (s_valid && s_ready) begin
                w.kind    = s_kind;
                w.cell_x  = s_cell_x;
                w.cell_y  = s_cell_y;
                w.heading = s_heading;
                apply_word(w);
            end
            // accepted result word
            if (m_valid && m_ready) begin
                got.closed     = m_closed;
                got.out_of_map = m_out_of_map;
                if (expected_results.size() == 0) begin
                    want = '0;
                    note_mismatch("result with nothing pending", want, got);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.out_of_map)
                        off_map_results++;
                    else if (want.closed)
                        closed_hits++;
                    if (got.closed !== want.closed || got.out_of_map !== want.out_of_map)
                        note_mismatch("wrong result", want, got);
                end
            end
        end
    end

    // ---------------------------------------------------------------- driver

    int burst_left = 1;
    int gap_left   = 0;

    // Bursts of words with random gaps; a word stays put until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_valid   <= 1'b1;
                s_kind    <= pending_words[0].kind;
                s_cell_x  <= pending_words[0].cell_x;
                s_cell_y  <= pending_words[0].cell_y;
                s_heading <= pending_words[0].heading;
                void'(pending_words.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    int rx_mode   = RX_OPEN;
    int rx_left   = 0;
    int hold_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            // long hold-off on request, counted here
            if (hold_served < hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (rx_left <= 0) begin
                    rx_mode = $urandom_range(RX_OPEN, RX_TOGGLE);
                    rx_left = $urandom_range(16, 160);
                end
                rx_left--;
                case (rx_mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= $urandom_range(0, 1);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= rx_left[0];
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random cell guaranteed to be on the planned map
    function automatic void on_map_spot(output logic [COORD_W-1:0] x,
                                        output logic [COORD_W-1:0] y);
        int unsigned ymax;
        int unsigned xmax;
        int unsigned yv;
        ymax = (MAX_CELLS - 1) / plan_cells_x;
        if (ymax > plan_cells_y - 1)
            ymax = plan_cells_y - 1;
        yv   = $urandom_range(0, ymax);
        xmax = (MAX_CELLS - 1) - yv * plan_cells_x;
        if (xmax > plan_cells_x - 1)
            xmax = plan_cells_x - 1;
        x = COORD_W'($urandom_range(0, xmax));
        y = COORD_W'(yv);
    endfunction

    // Program the geometry and bin width, then choose hot cells and headings
    task automatic set_geometry(input int unsigned cx, input int unsigned cy,
                                input int unsigned bw);
        int bwi;
        int e;
        cfg_write(CFG_CELLS_X, cx);
        cfg_write(CFG_CELLS_Y, cy);
        cfg_write(CFG_BIN_WIDTH, bw);
        plan_cells_x   = cx;
        plan_cells_y   = cy;
        plan_bin_width = bw;
        hot_count = (cx > 0 && cy > 0) ? HOT_CELLS : 0;
        for (int i = 0; i < hot_count; i++)
            on_map_spot(hot_x[i], hot_y[i]);
        bwi = (bw == 0) ? 1 : int'(bw);
        for (int i = 0; i < HOT_HEADS; i++) begin
            if (i < 3) begin
                hot_heads[i] = int'($signed(HEAD_W'($urandom)));
            end else begin
                // just on or just below a bin boundary
                e = bwi * int'($urandom_range(0, 64)) - int'($urandom_range(0, 1));
                hot_heads[i] = ((e % FULL_TURN) + FULL_TURN) % FULL_TURN;
            end
        end
        settings_run++;
        @(negedge aclk);
    endtask

    function automatic map_word_t make_word();
        map_word_t w;
        int pick;
        int hv;
        int k;
        pick      = $urandom_range(0, 99);
        w.kind    = ($urandom_range(0, 4) < 2) ? KIND_CLOSE : KIND_QUERY;
        w.cell_x  = COORD_W'($urandom);
        w.cell_y  = COORD_W'($urandom);
        w.heading = HEAD_W'($urandom);
        if (pick < 4) begin
            w.kind = KIND_EPOCH;
        end else if (pick < 6) begin
            w.kind = KIND_NONE;
        end else if (pick < 70 && hot_count > 0) begin
            // revisit a hot cell at a hot heading, possibly a few turns away
            k = $urandom_range(0, hot_count - 1);
            w.cell_x = hot_x[k];
            w.cell_y = hot_y[k];
            hv = hot_heads[$urandom_range(0, HOT_HEADS - 1)];
            k  = hv + FULL_TURN * (int'($urandom_range(0, 10)) - 5);
            if (k >= -32768 && k <= 32767)
                hv = k;
            w.heading = HEAD_W'(hv);
        end else if (pick < 85 && hot_count > 0) begin
            on_map_spot(w.cell_x, w.cell_y);
        end else if (pick < 92) begin
            // on the right or bottom border of the grid, or just past it
            w.cell_x = COORD_W'(plan_cells_x - $urandom_range(0, 1));
            w.cell_y = COORD_W'($urandom_range(0, plan_cells_y));
            if ($urandom_range(0, 1)) begin
                w.cell_x = COORD_W'($urandom_range(0, plan_cells_x));
                w.cell_y = COORD_W'(plan_cells_y - $urandom_range(0, 1));
            end
        end
        return w;
    endfunction

    task automatic push_word(input logic [KIND_W-1:0] kind, input int x, input int y,
                             input int h);
        map_word_t w;
        w.kind    = kind;
        w.cell_x  = COORD_W'(x);
        w.cell_y  = COORD_W'(y);
        w.heading = HEAD_W'(h);
        pending_words.push_back(w);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
        // closes and epoch words leave no result behind; let them drain
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(input int unsigned cx, input int unsigned cy,
                              input int unsigned bw, input int n, input bit long_hold);
        map_word_t w;
        int counted;
        counted = 0;
        set_geometry(cx, cy, bw);
        while (counted < n) begin
            w = make_word();
            pending_words.push_back(w);
            if (w.kind != KIND_NONE)
                counted++;
        end
        if (long_hold)
            hold_requests++;
        wait_idle();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: bin edges, heading wrap, borders, epoch clear, unused kind
        set_geometry(64, 64, 160);
        push_word(KIND_QUERY, 0, 0, 0);
        push_word(KIND_CLOSE, 0, 0, 0);
        push_word(KIND_QUERY, 0, 0, 0);
        push_word(KIND_QUERY, 0, 0, 159);
        push_word(KIND_QUERY, 0, 0, 160);
        push_word(KIND_CLOSE, 0, 0, -1);
        push_word(KIND_QUERY, 0, 0, 5759);
        push_word(KIND_CLOSE, 63, 63, -32768);
        push_word(KIND_QUERY, 63, 63, 1792);
        push_word(KIND_QUERY, 63, 63, 32767);
        push_word(KIND_CLOSE, 63, 63, 32767);
        push_word(KIND_QUERY, 63, 63, 3967);
        push_word(KIND_QUERY, 64, 0, 0);
        push_word(KIND_QUERY, 0, 64, 0);
        push_word(KIND_QUERY, 4095, 4095, -32768);
        push_word(KIND_CLOSE, 64, 5, 0);
        push_word(KIND_QUERY, 0, 5, 0);
        push_word(KIND_NONE, 4095, 4095, -1);
        push_word(KIND_QUERY, 0, 0, 0);
        push_word(KIND_EPOCH, 0, 0, 0);
        push_word(KIND_QUERY, 0, 0, 0);
        push_word(KIND_QUERY, 63, 63, 1792);
        push_word(KIND_CLOSE, 1, 0, 5759);
        push_word(KIND_QUERY, 1, 0, -1);
        wait_idle();

        // random phases over geometry and bin width, extremes included
        run_random(64, 64, 160, 150, 1'b1);
        run_random(64, 64, 0, 60, 1'b0);
        run_random(4096, 1, 90, 100, 1'b0);
        run_random(1, 4096, 5760, 80, 1'b0);
        run_random(100, 50, 1, 100, 1'b0);
        run_random(8191, 8191, 8191, 60, 1'b0);
        run_random(0, 7, 300, 30, 1'b0);
        run_random(4096, 4096, 200, 60, 1'b0);
        run_random(13, 9, 450, 120, 1'b1);
        run_random(1, 1, 90, 40, 1'b0);

        $display("covered %0d words incl. %0d epoch starts over %0d register settings",
                 words_accepted, epochs_started, settings_run);
        $display("checked %0d query results: %0d closed on map, %0d off map; %0d mismatches",
                 results_checked, closed_hits, off_map_results, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
